### rtl/kss_pkg.sv
package kss_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned RANK_W     = 11;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned DEPTH_DEF  = 1024;

  localparam logic [RANK_W-1:0] RANK_RESET = RANK_W'(512);

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_USE_MEDIAN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RANK       = 1'b1;

endpackage

### rtl/kss_if.sv
interface kss_in_if;
  import kss_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      last_item;
  modport source (output valid, value, last_item, input ready);
  modport sink   (input valid, value, last_item, output ready);
endinterface

interface kss_out_if;
  import kss_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] selected_value;
  logic                      rank_error;
  modport source (output valid, selected_value, rank_error, input ready);
  modport sink   (input valid, selected_value, rank_error, output ready);
endinterface

interface kss_cfg_if;
  import kss_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/kth_smallest_select.sv
// Channel  Dir  Payload                         Transfer
// in_ch    in   value[31:0] s, last_item        valid & ready
// out_ch   out  selected_value[31:0] s, rank_error  valid & ready
// cfg_ch   in   index (0 use_median, 1 rank), data  valid & ready (ready always high)
//
// A non-closing item is written to the store (items past DEPTH are dropped);
// items stream at one per cycle while in_ch is ready. The closing item starts
// a count-and-compare search over the stored set (one memory read port, one
// comparator) that tries at most n candidates; a rank of zero or above n, or an
// empty set, skips the search and flags rank_error. Reset clears the sequencer,
// the fill count and the registers; the store itself is not cleared. in_ch is
// not ready while a search runs or while the result waits on out_ch.
module kth_smallest_select #(
  parameter int unsigned DEPTH = kss_pkg::DEPTH_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  kss_in_if.sink  in_ch,
  kss_out_if.source out_ch,
  kss_cfg_if.sink cfg_ch
);
  import kss_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned KW = (CW > RANK_W) ? CW : RANK_W;

  typedef enum logic [2:0] {
    S_LOAD, S_CRD, S_CLAT, S_SRD, S_SCMP, S_CHK, S_OUT
  } state_e;

  state_e state_q;
  logic [CW-1:0] cnt_q;
  logic [CW-1:0] num_q;
  logic [KW-1:0] k_q;
  logic [CW-1:0] cand_idx_q;
  logic [CW-1:0] scan_idx_q;
  logic [CW-1:0] lt_q;
  logic [CW-1:0] le_q;
  logic signed [VALUE_W-1:0] cand_q;
  logic signed [VALUE_W-1:0] res_val_q;
  logic res_err_q;
  logic use_median_q;
  logic [RANK_W-1:0] rank_q;

  logic signed [VALUE_W-1:0] mem [DEPTH];
  logic signed [VALUE_W-1:0] rd_data_q;
  logic [AW-1:0] rd_addr;

  logic in_xfer, store_en;
  logic [CW-1:0] n_close;
  logic [KW-1:0] k_close;

  assign in_ch.ready = (state_q == S_LOAD);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign store_en    = in_xfer && (cnt_q < CW'(DEPTH));
  assign n_close     = store_en ? cnt_q + 1'b1 : cnt_q;
  assign k_close     = use_median_q ? KW'((n_close - 1'b1) >> 1) + 1'b1 : KW'(rank_q);

  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid          = (state_q == S_OUT);
  assign out_ch.selected_value = res_val_q;
  assign out_ch.rank_error     = res_err_q;

  // Pick the read address: candidate on its read cycle, scan index otherwise
  assign rd_addr = (state_q == S_CRD) ? cand_idx_q[AW-1:0] : scan_idx_q[AW-1:0];

  // Store: write on load, registered read
  always_ff @(posedge clk_i) begin
    if (store_en) begin
      mem[cnt_q[AW-1:0]] <= in_ch.value;
    end
    rd_data_q <= mem[rd_addr];
  end

  // Hold configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_median_q <= 1'b1;
      rank_q       <= RANK_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        REG_USE_MEDIAN: use_median_q <= cfg_ch.data[0];
        REG_RANK:       rank_q       <= cfg_ch.data[RANK_W-1:0];
        default:        ;
      endcase
    end
  end

  // Sequencer: load, then count smaller and equal elements per candidate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_LOAD;
      cnt_q      <= '0;
      num_q      <= '0;
      k_q        <= '0;
      cand_idx_q <= '0;
      scan_idx_q <= '0;
      lt_q       <= '0;
      le_q       <= '0;
      cand_q     <= '0;
      res_val_q  <= '0;
      res_err_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_LOAD: begin
          if (in_xfer) begin
            if (!in_ch.last_item) begin
              cnt_q <= n_close;
            end else begin
              cnt_q      <= '0;
              num_q      <= n_close;
              k_q        <= k_close;
              cand_idx_q <= '0;
              if (k_close == '0 || k_close > KW'(n_close) || n_close == '0) begin
                res_val_q <= '0;
                res_err_q <= 1'b1;
                state_q   <= S_OUT;
              end else begin
                state_q <= S_CRD;
              end
            end
          end
        end
        S_CRD: state_q <= S_CLAT;
        S_CLAT: begin
          cand_q     <= rd_data_q;
          scan_idx_q <= '0;
          lt_q       <= '0;
          le_q       <= '0;
          state_q    <= S_SRD;
        end
        S_SRD: state_q <= S_SCMP;
        S_SCMP: begin
          if (rd_data_q < cand_q) begin
            lt_q <= lt_q + 1'b1;
            le_q <= le_q + 1'b1;
          end else if (rd_data_q == cand_q) begin
            le_q <= le_q + 1'b1;
          end
          scan_idx_q <= scan_idx_q + 1'b1;
          state_q    <= (scan_idx_q + 1'b1 == num_q) ? S_CHK : S_SRD;
        end
        S_CHK: begin
          // The candidate is the answer when k falls inside its run of ties
          if (KW'(lt_q) < k_q && k_q <= KW'(le_q)) begin
            res_val_q <= cand_q;
            res_err_q <= 1'b0;
            state_q   <= S_OUT;
          end else begin
            cand_idx_q <= cand_idx_q + 1'b1;
            state_q    <= S_CRD;
          end
        end
        S_OUT: begin
          if (out_ch.ready) state_q <= S_LOAD;
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.rank_error |-> out_ch.selected_value == '0)
    else $error("error result carries a nonzero value");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("fill count beyond depth");

  a_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CHK |-> lt_q <= le_q && le_q <= num_q && le_q != '0)
    else $error("inconsistent scan counts");

  a_cand_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CRD |-> cand_idx_q < num_q)
    else $error("candidate index ran past the set");

endmodule

### tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kss_pkg::*;

  typedef logic signed [VALUE_W-1:0] word_t;

  typedef struct packed {
    word_t value;
    logic  err;
  } pick_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e kind;
    word_t     value;
    logic      last;
    logic      typed;
    pick_t     want;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } row_t;

  localparam word_t W_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam word_t W_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  logic clk_i;
  logic rst_ni;
  logic idle_en;
  int   fail_cnt;

  kss_in_if  in_if ();
  kss_out_if out_if ();
  kss_cfg_if cfg_if ();

  kth_smallest_select dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // Shadow state of the selector
  word_t              set_store [DEPTH_DEF];
  int                 set_fill;
  logic               median_mode;
  logic [RANK_W-1:0]  sel_rank;
  pick_t              pick_q [$];
  row_t               rows [$];

  // Work out the order statistic of the open set
  function automatic pick_t select_kth();
    pick_t r;
    word_t w [];
    word_t v;
    int    n;
    int    k;
    int    j;
    n = set_fill;
    k = median_mode ? (n - 1) / 2 + 1 : int'(sel_rank);
    if (k == 0 || k > n) begin
      r.value = '0;
      r.err   = 1'b1;
      return r;
    end
    w = new[n];
    for (int i = 0; i < n; i++) w[i] = set_store[i];
    for (int i = 1; i < n; i++) begin
      v = w[i];
      j = i;
      while (j > 0 && w[j-1] > v) begin
        w[j] = w[j-1];
        j--;
      end
      w[j] = v;
    end
    r.value = w[k-1];
    r.err   = 1'b0;
    return r;
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop
  initial begin
    #60ms;
    $display("FAIL kth_smallest_select");
    $finish;
  end

  // Result side: check each transfer, stall in random bursts
  initial begin
    int stall;
    pick_t e;
    stall = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        if (pick_q.size() == 0) begin
          $error("unexpected result value=%0d err=%0b",
                 out_if.selected_value, out_if.rank_error);
          fail_cnt++;
        end else begin
          e = pick_q.pop_front();
          if (out_if.selected_value !== e.value) begin
            $error("selected_value expected %0d actual %0d", e.value,
                   out_if.selected_value);
            fail_cnt++;
          end
          if (out_if.rank_error !== e.err) begin
            $error("rank_error expected %0b actual %0b", e.err, out_if.rank_error);
            fail_cnt++;
          end
        end
      end
      if (stall > 0) begin
        stall--;
        out_if.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(0, 3);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Write one register and mirror it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == REG_USE_MEDIAN) median_mode = d[0];
    else sel_rank = d[RANK_W-1:0];
    @(posedge clk_i);
  endtask

  // Hold until every result is back, then let the block settle
  task automatic drain();
    while (pick_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Send one element; typed expectation overrides the prediction when given
  task automatic send_value(word_t v, logic last, logic typed, pick_t want);
    pick_t p;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.value     <= v;
    in_if.last_item <= last;
    do @(posedge clk_i); while (!in_if.ready);
    if (set_fill < DEPTH_DEF) begin
      set_store[set_fill] = v;
      set_fill++;
    end
    if (last) begin
      p = select_kth();
      pick_q.push_back(typed ? want : p);
      set_fill = 0;
    end
  endtask

  task automatic add_item(word_t v, logic last, logic typed, word_t wv, logic we);
    row_t r;
    r.kind = ROW_ITEM;
    r.value = v;
    r.last = last;
    r.typed = typed;
    r.want.value = wv;
    r.want.err = we;
    r.idx = '0;
    r.data = '0;
    rows.push_back(r);
  endtask

  task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    row_t r;
    r.kind = ROW_CFG;
    r.value = '0;
    r.last = 1'b0;
    r.typed = 1'b0;
    r.want = '0;
    r.idx = idx;
    r.data = d;
    rows.push_back(r);
  endtask

  // Pick an element: full range, extremes, or a narrow pool that forces ties
  function automatic word_t rand_value();
    case ($urandom_range(0, 5))
      0:       return W_MIN;
      1:       return W_MAX;
      2, 3:    return word_t'($urandom_range(0, 6)) - 3;
      default: return word_t'($urandom);
    endcase
  endfunction

  // Stimulus
  initial begin
    int n;
    int sent;
    logic [CFG_DATA_W-1:0] r;
    pick_t none;
    none = '0;
    fail_cnt = 0;
    idle_en = 1'b1;
    set_fill = 0;
    median_mode = 1'b1;
    sel_rank = RANK_RESET;
    in_if.valid = 1'b0;
    in_if.value = '0;
    in_if.last_item = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    add_item(-5, 1'b1, 1'b1, -5, 1'b0);
    add_item(W_MIN, 1'b0, 1'b0, 0, 1'b0);
    add_item(W_MAX, 1'b0, 1'b0, 0, 1'b0);
    add_item(0, 1'b1, 1'b1, 0, 1'b0);
    add_item(W_MAX, 1'b1, 1'b1, W_MAX, 1'b0);
    add_item(3, 1'b0, 1'b0, 0, 1'b0);
    add_item(3, 1'b0, 1'b0, 0, 1'b0);
    add_item(1, 1'b0, 1'b0, 0, 1'b0);
    add_item(3, 1'b1, 1'b0, 0, 1'b0);
    add_cfg(REG_USE_MEDIAN, 0);
    add_cfg(REG_RANK, 0);
    add_item(7, 1'b1, 1'b1, 0, 1'b1);
    add_cfg(REG_RANK, 3);
    add_item(1, 1'b0, 1'b0, 0, 1'b0);
    add_item(2, 1'b1, 1'b1, 0, 1'b1);
    add_cfg(REG_RANK, 2);
    add_item(9, 1'b0, 1'b0, 0, 1'b0);
    add_item(-9, 1'b0, 1'b0, 0, 1'b0);
    add_item(9, 1'b1, 1'b0, 0, 1'b0);
    add_cfg(REG_RANK, 2047);
    add_item(W_MIN, 1'b1, 1'b1, 0, 1'b1);
    add_cfg(REG_USE_MEDIAN, 1);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        in_if.valid <= 1'b0;
        drain();
        write_reg(rows[i].idx, rows[i].data);
      end else begin
        send_value(rows[i].value, rows[i].last, rows[i].typed, rows[i].want);
      end
    end
    in_if.valid <= 1'b0;
    drain();

    // Fill the store past its depth; the closing element is dropped
    write_reg(REG_USE_MEDIAN, 0);
    write_reg(REG_RANK, 1);
    send_value(-100, 1'b0, 1'b0, none);
    for (int i = 1; i < DEPTH_DEF; i++)
      send_value(word_t'($urandom_range(0, 32'h7fff_fff0)), 1'b0, 1'b0, none);
    send_value(W_MIN, 1'b1, 1'b1, '{value: -100, err: 1'b0});
    in_if.valid <= 1'b0;
    drain();

    // Random phases over several settings, extremes first
    for (int ph = 0; ph < 8; ph++) begin
      idle_en = (ph < 6);
      case (ph)
        0:       r = 1;
        1:       r = 1024;
        2:       r = 0;
        3:       r = 2047;
        default: r = CFG_DATA_W'($urandom_range(1, 6));
      endcase
      write_reg(REG_RANK, r);
      write_reg(REG_USE_MEDIAN,
                (ph % 3 == 2) ? CFG_DATA_W'(1) : CFG_DATA_W'($urandom_range(0, 1)));
      sent = 0;
      while (sent < 24) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
          send_value(rand_value(), i == n - 1, 1'b0, none);
        sent += n;
      end
      in_if.valid <= 1'b0;
      drain();
    end

    repeat (50) @(posedge clk_i);
    if (fail_cnt == 0 && pick_q.size() == 0)
      $display("PASS kth_smallest_select");
    else
      $display("FAIL kth_smallest_select");
    $finish;
  end

endmodule

### filelist.f
rtl/kss_pkg.sv
rtl/kss_if.sv
rtl/kth_smallest_select.sv
tb/tb.sv
